/* design/assert_macros.svh */
// Assertion macros used by the checker file of this block.
// Needs nothing else; take it in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define PIP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define PIP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* design/pip_pkg.sv */
// Package for the point-in-polygon block: default sizes, operation codes, fixed constants.
// No dependencies; imported by the top level and the checker.
package pip_pkg;

    localparam int MAX_VERTICES_DEF = 256;
    localparam int COORD_BITS_DEF   = 24;

    // A polygon needs at least this many vertices, else the point is outside
    localparam int MIN_VERTICES     = 3;

    // Operation carried by a command beat
    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

endpackage

/* design/point_in_polygon_test.sv */
// Even-odd point-in-polygon test; vertices in one synchronous RAM (x and y per word).
// Load beat: busy stays low. Query beat with count n >= 3: result strobe after the
// prime read, one RAM read per edge, then difference, multiply and compare stages;
// busy high until the result cycle, so a new query is taken only after the result.
// Query with n < 3: result next cycle, busy low. Results are never stalled by the receiver.
// Synchronous active-low reset clears control and vertex_count; RAM undefined until written.
module point_in_polygon_test
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int COORD_BITS   = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // command channel
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_op,
    input  logic [$clog2(MAX_VERTICES)-1:0]   i_vertex_index,
    input  logic signed [COORD_BITS-1:0] i_coord_x,
    input  logic signed [COORD_BITS-1:0] i_coord_y,
    // configuration: vertex_count
    input  logic                         i_cfg_we,
    input  logic [$clog2(MAX_VERTICES+1)-1:0] i_cfg_data,
    // result
    output logic                         o_valid,
    output logic                         o_inside_res
);

    localparam int CW    = COORD_BITS;
    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int PW    = 2 * CW + 2;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    // control state
    t_state             r_state;
    logic [CNT_W-1:0]   r_vcount;
    logic [CNT_W-1:0]   r_n;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_prime;
    logic               r_issuing;
    logic               r_v0, r_p0, r_l0;
    logic               r_v1, r_l1;
    logic               r_v2, r_l2;
    logic               r_parity;
    logic               r_valid;
    logic               r_inside;

    // payload
    logic [2*CW-1:0]    mem [MAX_VERTICES];
    logic [2*CW-1:0]    r_rdata;
    logic signed [CW-1:0] r_px, r_py;
    logic signed [CW-1:0] r_xo, r_yo;
    logic signed [CW:0] r_dyt, r_dx, r_dy, r_dxt;
    logic               r_f1, r_f2;
    logic signed [PW-1:0] r_lhs, r_rhs;

    logic               query_acc, load_acc, load_in_range;
    logic [CNT_W-1:0]   n_clamped;
    logic [CNT_W-1:0]   w_nm1;
    logic               rd_en, rd_last;
    logic [IDX_W-1:0]   rd_addr;
    logic signed [CW-1:0] w_xn, w_yn, w_x1, w_y1, w_x2, w_y2;
    logic               w_straddle;
    logic               w_less, n_parity;

    // handshake decode
    assign query_acc     = start && !busy && (i_op == OP_QUERY);
    assign load_acc      = start && !busy && (i_op == OP_LOAD);
    assign load_in_range = CNT_W'(i_vertex_index) < CNT_W'(MAX_VERTICES);
    assign n_clamped     = (r_vcount > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
                                                             : r_vcount;

    // read issue: prime read of the last vertex, then vertices 0 .. n-1
    assign w_nm1   = r_n - CNT_W'(1);
    assign rd_en   = (r_state == S_RUN) && (r_prime || r_issuing);
    assign rd_addr = r_prime ? w_nm1[IDX_W-1:0] : r_cnt[IDX_W-1:0];
    assign rd_last = !r_prime && (r_cnt == w_nm1);

    // vertex RAM, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (load_acc && load_in_range) begin
            mem[i_vertex_index] <= {i_coord_x, i_coord_y};
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // edge stage: order endpoints by x, straddle test, differences
    assign w_xn       = $signed(r_rdata[2*CW-1:CW]);
    assign w_yn       = $signed(r_rdata[CW-1:0]);
    assign w_x1       = (w_xn > r_xo) ? r_xo : w_xn;
    assign w_y1       = (w_xn > r_xo) ? r_yo : w_yn;
    assign w_x2       = (w_xn > r_xo) ? w_xn : r_xo;
    assign w_y2       = (w_xn > r_xo) ? w_yn : r_yo;
    assign w_straddle = (w_xn < r_px) == (r_px <= r_xo);

    always_ff @(posedge i_clk) begin
        if (query_acc) begin
            r_px <= i_coord_x;
            r_py <= i_coord_y;
        end
        if (r_v0) begin
            r_xo  <= w_xn;
            r_yo  <= w_yn;
            r_dyt <= $signed({r_py[CW-1], r_py}) - $signed({w_y1[CW-1], w_y1});
            r_dx  <= $signed({w_x2[CW-1], w_x2}) - $signed({w_x1[CW-1], w_x1});
            r_dy  <= $signed({w_y2[CW-1], w_y2}) - $signed({w_y1[CW-1], w_y1});
            r_dxt <= $signed({r_px[CW-1], r_px}) - $signed({w_x1[CW-1], w_x1});
            r_f1  <= w_straddle;
        end
        // multiply stage
        r_lhs <= PW'(r_dyt) * PW'(r_dx);
        r_rhs <= PW'(r_dy) * PW'(r_dxt);
        r_f2  <= r_f1;
    end

    // compare stage
    assign w_less   = r_lhs < r_rhs;
    assign n_parity = r_parity ^ (r_f2 && w_less);

    // sequencer and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_vcount  <= '0;
            r_n       <= '0;
            r_cnt     <= '0;
            r_prime   <= 1'b0;
            r_issuing <= 1'b0;
            r_v0      <= 1'b0;
            r_p0      <= 1'b0;
            r_l0      <= 1'b0;
            r_v1      <= 1'b0;
            r_l1      <= 1'b0;
            r_v2      <= 1'b0;
            r_l2      <= 1'b0;
            r_parity  <= 1'b0;
            r_valid   <= 1'b0;
            r_inside  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_vcount <= i_cfg_data;
            end
            r_valid <= 1'b0;
            r_v0    <= rd_en;
            r_p0    <= r_prime;
            r_l0    <= rd_last;
            r_v1    <= r_v0 && !r_p0;
            r_l1    <= r_l0 && !r_p0;
            r_v2    <= r_v1;
            r_l2    <= r_l1;
            case (r_state)
                S_IDLE: begin
                    if (query_acc) begin
                        if (n_clamped < CNT_W'(MIN_VERTICES)) begin
                            r_valid  <= 1'b1;
                            r_inside <= 1'b0;
                        end else begin
                            r_state   <= S_RUN;
                            r_n       <= n_clamped;
                            r_cnt     <= '0;
                            r_prime   <= 1'b1;
                            r_issuing <= 1'b1;
                            r_parity  <= 1'b0;
                        end
                    end
                end
                S_RUN: begin
                    if (r_prime) begin
                        r_prime <= 1'b0;
                    end else if (r_issuing) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                        if (rd_last) begin
                            r_issuing <= 1'b0;
                        end
                    end
                    if (r_v2) begin
                        r_parity <= n_parity;
                        if (r_l2) begin
                            r_valid  <= 1'b1;
                            r_inside <= n_parity;
                            r_state  <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = (r_state == S_RUN);
    assign o_valid      = r_valid;
    assign o_inside_res = r_inside;

endmodule

/* design/pip_checker.sv */
// Port-level checker for point_in_polygon_test, attached with a bind.
// Depends on assert_macros.svh and pip_pkg.
`include "assert_macros.svh"

module pip_checker
    import pip_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_op,
    input logic o_valid
);

    // result beat never overlaps a running query
    `PIP_ASSERT_NOW(a_valid_not_busy, i_clk, i_rst_n, o_valid, !busy)

    // a load beat produces no result
    `PIP_ASSERT_NEXT(a_load_silent, i_clk, i_rst_n, start && !busy && i_op == OP_LOAD, !o_valid)

    // a query beat either starts the edge walk or answers at once
    `PIP_ASSERT_NEXT(a_query_moves, i_clk, i_rst_n, start && !busy && i_op == OP_QUERY, busy || o_valid)

    // end of a walk always comes with its result
    `PIP_ASSERT_NOW(a_done_result, i_clk, i_rst_n, $fell(busy) && $past(i_rst_n), o_valid)

endmodule

bind point_in_polygon_test pip_checker u_pip_checker (.*);
